// ===== design/cld_pkg.sv =====
// Types and constants shared by the console line discipline.
package cld_pkg;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [2:0] CFG_WRITE_MODE  = 3'd0;
  localparam logic [2:0] CFG_CRLF_EXPAND = 3'd1;
  localparam logic [2:0] CFG_LINE_MODE   = 3'd2;
  localparam logic [2:0] CFG_ECHO_ENABLE = 3'd3;
  localparam logic [2:0] CFG_EDIT_MODE   = 3'd4;
  localparam logic [2:0] CFG_MAX_LENGTH  = 3'd5;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [6:0] position;
    logic [7:0] length;
  } res_t;

endpackage

// ===== design/console_line_discipline.sv =====
// Console line discipline: byte transmit, line receive and edit, one byte per item.
//
//  channel | signals                                   | direction
//  item    | item_valid, item_stall, in_byte           | in
//  result  | result_valid, result_stall, kind,         | out
//          | data_byte, position, length, last         |
//  config  | cfg_write, cfg_index, cfg_data            | in
//
// An item enters an input register, is expanded into a list of up to three
// results, and the list drains one result per cycle into the output register
// unless result_stall holds it. Each item passes the input register, the list
// and the output register in turn; the list refills as its last result leaves.
// Synchronous reset restores register defaults and clears the line position.
// result_stall holds the output register; the list and input register back up
// behind it and item_stall rises once the input register cannot move on.
module console_line_discipline
  import cld_pkg::*;
#(
  parameter int LINE_CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] in_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [6:0] position,
  output logic [7:0] length,
  output logic       last,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int PosMax = (LINE_CAPACITY < 255) ? LINE_CAPACITY : 255;
  localparam int PW     = $clog2(PosMax + 1);

  logic          write_mode, crlf_expand, line_mode, echo_enable, edit_mode;
  logic [7:0]    max_length;
  logic [PW-1:0] line_position, line_position_next;

  logic       a_valid;
  logic [7:0] a_byte;

  res_t       p_res [3];
  logic [1:0] p_cnt, p_idx;

  res_t       n_res [3];
  logic [1:0] n_cnt;

  logic          o_take, move, free, a_consume, accept;
  logic [7:0]    m;
  logic [PW-1:0] lim;
  logic [PW:0]   inc;

  assign o_take    = !result_valid || !result_stall;
  assign move      = (p_idx != p_cnt) && o_take;
  assign free      = (p_idx == p_cnt) || ((p_idx + 2'd1 == p_cnt) && o_take);
  assign a_consume = a_valid && free;
  assign item_stall = a_valid && !free;
  assign accept    = item_valid && !item_stall;

  always_comb begin
    m = (max_length == 8'd0) ? 8'd1 : max_length;
    if (int'(m) > LINE_CAPACITY) begin
      lim = PW'(PosMax);
    end else begin
      lim = PW'(m);
    end
  end

  always_comb begin
    n_res[0] = '0;
    n_res[1] = '0;
    n_res[2] = '0;
    n_cnt = 2'd0;
    line_position_next = line_position;
    inc = {1'b0, line_position} + (PW+1)'(1);
    if (write_mode) begin
      if (line_mode && a_byte == CH_NUL) begin
        n_res[0] = '{KIND_DONE, 8'd0, 7'd0, 8'(line_position)};
        n_cnt = 2'd1;
        line_position_next = '0;
      end else begin
        line_position_next = PW'(inc);
        if (crlf_expand && a_byte == CH_LF) begin
          n_res[n_cnt] = '{KIND_TX, CH_CR, 7'd0, 8'd0};
          n_cnt = n_cnt + 2'd1;
        end
        n_res[n_cnt] = '{KIND_TX, a_byte, 7'd0, 8'd0};
        n_cnt = n_cnt + 2'd1;
        if (inc >= {1'b0, lim}) begin
          n_res[n_cnt] = '{KIND_DONE, 8'd0, 7'd0, 8'(inc)};
          n_cnt = n_cnt + 2'd1;
          line_position_next = '0;
        end
      end
    end else if (edit_mode && (a_byte == CH_BS || a_byte == CH_DEL)) begin
      if (line_position != '0) begin
        line_position_next = line_position - PW'(1);
        n_res[0] = '{KIND_TX, CH_BS, 7'd0, 8'd0};
        n_res[1] = '{KIND_TX, CH_SP, 7'd0, 8'd0};
        n_res[2] = '{KIND_TX, CH_BS, 7'd0, 8'd0};
        n_cnt = 2'd3;
      end
    end else if (line_mode && (a_byte == CH_CR || a_byte == CH_LF)) begin
      if (line_position < lim) begin
        n_res[n_cnt] = '{KIND_STORE, 8'd0, 7'(8'(line_position)), 8'd0};
        n_cnt = n_cnt + 2'd1;
      end
      n_res[n_cnt] = '{KIND_DONE, 8'd0, 7'd0, 8'(line_position)};
      n_cnt = n_cnt + 2'd1;
      line_position_next = '0;
    end else begin
      if (echo_enable) begin
        n_res[n_cnt] = '{KIND_TX, a_byte, 7'd0, 8'd0};
        n_cnt = n_cnt + 2'd1;
      end
      if (line_position < lim) begin
        n_res[n_cnt] = '{KIND_STORE, a_byte, 7'(8'(line_position)), 8'd0};
        n_cnt = n_cnt + 2'd1;
        line_position_next = PW'(inc);
      end
      if (!edit_mode && line_position_next >= lim) begin
        n_res[n_cnt] = '{KIND_DONE, 8'd0, 7'd0, 8'(line_position_next)};
        n_cnt = n_cnt + 2'd1;
        line_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_mode  <= 1'b0;
      crlf_expand <= 1'b1;
      line_mode   <= 1'b1;
      echo_enable <= 1'b1;
      edit_mode   <= 1'b1;
      max_length  <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WRITE_MODE:  write_mode  <= cfg_data[0];
        CFG_CRLF_EXPAND: crlf_expand <= cfg_data[0];
        CFG_LINE_MODE:   line_mode   <= cfg_data[0];
        CFG_ECHO_ENABLE: echo_enable <= cfg_data[0];
        CFG_EDIT_MODE:   edit_mode   <= cfg_data[0];
        CFG_MAX_LENGTH:  max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      p_cnt         <= 2'd0;
      p_idx         <= 2'd0;
      result_valid  <= 1'b0;
      line_position <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_consume) begin
        a_valid <= 1'b0;
      end
      if (a_consume) begin
        p_cnt         <= n_cnt;
        p_idx         <= 2'd0;
        line_position <= line_position_next;
      end else if (move) begin
        p_idx <= p_idx + 2'd1;
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte <= in_byte;
    end
    if (a_consume) begin
      p_res <= n_res;
    end
    if (move) begin
      kind      <= p_res[p_idx].kind;
      data_byte <= p_res[p_idx].data_byte;
      position  <= p_res[p_idx].position;
      length    <= p_res[p_idx].length;
      last      <= (p_idx + 2'd1 == p_cnt);
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst) p_idx <= p_cnt)
    else $error("result list index past its count");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_DONE |-> last)
    else $error("complete result not marked last");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    int'(line_position) <= PosMax)
    else $error("line position out of range");
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> a_valid && p_idx != p_cnt)
    else $error("item stalled with empty result list");
`endif

endmodule
